FILE: rtl/core/tfx_pkg.sv
// ----------------------------------------------------------------------------
// tfx_pkg
// Shared types, codes and helpers for the tag-length-value field extractor.
// ----------------------------------------------------------------------------
package tfx_pkg;

   localparam int unsigned FifoDepth     = 4;
   localparam int unsigned PtrWidth      = $clog2(FifoDepth);
   localparam int unsigned CountWidth    = $clog2(FifoDepth + 1);
   localparam int unsigned CsrIndexWidth = 8;

   localparam logic [CsrIndexWidth-1:0] CSR_TARGET_TAG = CsrIndexWidth'(0);
   localparam logic [CsrIndexWidth-1:0] CSR_FIELD_TYPE = CsrIndexWidth'(1);
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_LEN    = CsrIndexWidth'(2);
   localparam logic [CsrIndexWidth-1:0] CSR_DEST_SIZE  = CsrIndexWidth'(3);

   localparam logic [2:0] TYPE_CHAR   = 3'd0;
   localparam logic [2:0] TYPE_SHORT  = 3'd1;
   localparam logic [2:0] TYPE_INT    = 3'd2;
   localparam logic [2:0] TYPE_LONG   = 3'd3;
   localparam logic [2:0] TYPE_FLOAT  = 3'd4;
   localparam logic [2:0] TYPE_DOUBLE = 3'd5;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_INCOMPLETE = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
   localparam logic [2:0] ST_BAD_RULE   = 3'd3;
   localparam logic [2:0] ST_TOO_LONG   = 3'd4;
   localparam logic [2:0] ST_MISMATCH   = 3'd5;

   typedef struct packed {
      logic        kind;
      logic [63:0] value;
      logic [2:0]  status;
      logic [31:0] field_length;
      logic        last;
   } result_type;

   function automatic logic [31:0] numeric_size(input logic [2:0] t);
      logic [31:0] n;
      case (t)
         TYPE_SHORT: n = 32'd2;
         TYPE_INT, TYPE_FLOAT: n = 32'd4;
         default: n = 32'd8;
      endcase
      return n;
   endfunction

   function automatic result_type make_status(input logic [2:0] st,
                                              input logic [31:0] len,
                                              input logic [63:0] acc,
                                              input logic char_f);
      result_type r;
      r.kind         = 1'b1;
      r.value        = 64'd0;
      r.status       = st;
      r.field_length = 32'd0;
      r.last         = 1'b1;
      if (st == ST_OK) begin
         r.field_length = len;
         if (!char_f) begin
            r.value = acc;
         end
      end
      return r;
   endfunction

   function automatic result_type make_byte(input logic [7:0] b);
      result_type r;
      r.kind         = 1'b0;
      r.value        = {56'd0, b};
      r.status       = ST_OK;
      r.field_length = 32'd0;
      r.last         = 1'b0;
      return r;
   endfunction

endpackage

FILE: rtl/core/tfx_if.sv
// ----------------------------------------------------------------------------
// tfx channel interfaces
// Byte input, result output and register write channels.
// ----------------------------------------------------------------------------
interface tfx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_message;
   modport source (output valid, output data_byte, output end_of_message, input ready);
   modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface tfx_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [63:0] value;
   logic [2:0]  status;
   logic [31:0] field_length;
   logic        last;
   modport source (output valid, output kind, output value, output status,
                   output field_length, output last, input ready);
   modport sink (input valid, input kind, input value, input status,
                 input field_length, input last, output ready);
endinterface

interface tfx_csr_if;
   logic                               valid;
   logic                               ready;
   logic [tfx_pkg::CsrIndexWidth-1:0]  index;
   logic [31:0]                        data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/tlv_field_extractor.sv
// ----------------------------------------------------------------------------
// tlv_field_extractor
// Tag-length-value record parser that extracts one configured field.
//
// req_chan carries one message byte per transaction with end_of_message on
// the final byte. rsp_chan gives char payload bytes (kind 0) and exactly one
// final status (kind 1, last 1) per message. csr_chan writes target_tag,
// field_type, max_len and dest_size at indexes 0 to 3; it is always ready.
// One byte is taken per cycle while the queue has room. A byte is held in
// an input register, then parsed combinationally and its up to two results
// are written into a four-entry result queue, from which the first result
// is offered. The input register advances while the queue has room for two
// results, so a stalled receiver backs up into req_chan.ready once three
// results wait in the queue. Reset clears the registers, the parser state
// and the queue; nothing is output until new bytes arrive.
// ----------------------------------------------------------------------------
module tlv_field_extractor (
   input logic       clock,
   input logic       reset,
   tfx_req_if.sink   req_chan,
   tfx_rsp_if.source rsp_chan,
   tfx_csr_if.sink   csr_chan
);
   import tfx_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_SKIP    = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_DONE    = 2'd3
   } phase_type;

   logic [31:0] target_tag_ff;
   logic [2:0]  field_type_ff;
   logic [31:0] max_len_ff;
   logic [31:0] dest_size_ff;

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_eom_ff;

   phase_type   phase_ff,     phase_in;
   logic [2:0]  hdr_cnt_ff,   hdr_cnt_in;
   logic [31:0] tag_ff,       tag_in;
   logic [31:0] len_ff,       len_in;
   logic [31:0] rem_ff,       rem_in;
   logic [63:0] acc_ff,       acc_in;
   logic        chk_ff,       chk_in;
   logic [2:0]  pend_ff,      pend_in;
   logic        char_ff,      char_in;

   result_type             fifo_ff [FifoDepth];
   logic [PtrWidth-1:0]    wr_ptr_ff;
   logic [PtrWidth-1:0]    rd_ptr_ff;
   logic [CountWidth-1:0]  cnt_ff;

   result_type  res0, res1;
   logic [1:0]  nres;
   logic        advance;
   logic        pop;

   assign advance = in_valid_ff && (cnt_ff <= CountWidth'(FifoDepth - 2));
   assign pop     = rsp_chan.valid && rsp_chan.ready;

   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid        = (cnt_ff != '0);
   assign rsp_chan.kind         = fifo_ff[rd_ptr_ff].kind;
   assign rsp_chan.value        = fifo_ff[rd_ptr_ff].value;
   assign rsp_chan.status       = fifo_ff[rd_ptr_ff].status;
   assign rsp_chan.field_length = fifo_ff[rd_ptr_ff].field_length;
   assign rsp_chan.last         = fifo_ff[rd_ptr_ff].last;

   always_comb begin
      result_type r [2];
      logic [1:0] n;
      logic [2:0] t;
      r[0]       = make_byte(8'd0);
      r[1]       = make_byte(8'd0);
      n          = 2'd0;
      t          = field_type_ff;
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      tag_in     = tag_ff;
      len_in     = len_ff;
      rem_in     = rem_ff;
      acc_in     = acc_ff;
      chk_in     = chk_ff;
      pend_in    = pend_ff;
      char_in    = char_ff;

      case (phase_ff)
         PH_HEADER: begin
            if (!hdr_cnt_ff[2]) begin
               tag_in = {tag_ff[23:0], in_byte_ff};
            end else begin
               len_in = {len_ff[23:0], in_byte_ff};
            end
            hdr_cnt_in = hdr_cnt_ff + 3'd1;
            if (hdr_cnt_in == 3'd0) begin
               rem_in = len_in;
               if (tag_in == target_tag_ff) begin
                  char_in = (t == TYPE_CHAR);
                  if (t == TYPE_CHAR) begin
                     if (max_len_ff > dest_size_ff) begin
                        pend_in = ST_BAD_RULE;
                     end else if (len_in > max_len_ff) begin
                        pend_in = ST_TOO_LONG;
                     end else begin
                        pend_in = ST_OK;
                     end
                  end else if (t <= TYPE_DOUBLE) begin
                     if (dest_size_ff != numeric_size(t) || len_in != numeric_size(t)) begin
                        pend_in = ST_MISMATCH;
                     end else begin
                        pend_in = ST_OK;
                     end
                  end else begin
                     pend_in = ST_BAD_RULE;
                  end
                  chk_in = (pend_in == ST_OK);
                  acc_in = 64'd0;
                  if (rem_in == 32'd0) begin
                     r[n[0]]  = make_status(pend_in, len_in, acc_in, char_in);
                     n        = n + 2'd1;
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end else if (rem_in != 32'd0) begin
                  phase_in = PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            rem_in = rem_ff - 32'd1;
            if (rem_in == 32'd0) begin
               phase_in = PH_HEADER;
            end
         end
         PH_PAYLOAD: begin
            if (chk_ff) begin
               if (char_ff) begin
                  r[n[0]] = make_byte(in_byte_ff);
                  n       = n + 2'd1;
               end else begin
                  acc_in = {acc_ff[55:0], in_byte_ff};
               end
            end
            rem_in = rem_ff - 32'd1;
            if (rem_in == 32'd0) begin
               r[n[0]]  = make_status(pend_ff, len_ff, acc_in, char_ff);
               n        = n + 2'd1;
               phase_in = PH_DONE;
            end
         end
         default: begin
         end
      endcase

      if (in_eom_ff) begin
         if (phase_in != PH_DONE) begin
            if (phase_in == PH_HEADER && hdr_cnt_in == 3'd0) begin
               r[n[0]] = make_status(ST_NOT_FOUND, len_in, acc_in, char_in);
            end else begin
               r[n[0]] = make_status(ST_INCOMPLETE, len_in, acc_in, char_in);
            end
            n = n + 2'd1;
         end
         phase_in   = PH_HEADER;
         hdr_cnt_in = 3'd0;
         tag_in     = 32'd0;
         len_in     = 32'd0;
         rem_in     = 32'd0;
         acc_in     = 64'd0;
         chk_in     = 1'b0;
         pend_in    = ST_OK;
         char_in    = 1'b0;
      end

      res0 = r[0];
      res1 = r[1];
      nres = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_tag_ff <= 32'd0;
         field_type_ff <= TYPE_CHAR;
         max_len_ff    <= 32'd0;
         dest_size_ff  <= 32'd0;
         in_valid_ff   <= 1'b0;
         phase_ff      <= PH_HEADER;
         hdr_cnt_ff    <= 3'd0;
         tag_ff        <= 32'd0;
         len_ff        <= 32'd0;
         rem_ff        <= 32'd0;
         acc_ff        <= 64'd0;
         chk_ff        <= 1'b0;
         pend_ff       <= ST_OK;
         char_ff       <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         cnt_ff        <= '0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.index)
               CSR_TARGET_TAG: target_tag_ff <= csr_chan.data;
               CSR_FIELD_TYPE: field_type_ff <= csr_chan.data[2:0];
               CSR_MAX_LEN:    max_len_ff    <= csr_chan.data;
               CSR_DEST_SIZE:  dest_size_ff  <= csr_chan.data;
               default: begin
               end
            endcase
         end

         if (req_chan.valid && req_chan.ready) begin
            in_valid_ff <= 1'b1;
            in_byte_ff  <= req_chan.data_byte;
            in_eom_ff   <= req_chan.end_of_message;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         if (advance) begin
            phase_ff   <= phase_in;
            hdr_cnt_ff <= hdr_cnt_in;
            tag_ff     <= tag_in;
            len_ff     <= len_in;
            rem_ff     <= rem_in;
            acc_ff     <= acc_in;
            chk_ff     <= chk_in;
            pend_ff    <= pend_in;
            char_ff    <= char_in;
            if (nres != 2'd0) begin
               fifo_ff[wr_ptr_ff] <= res0;
            end
            if (nres == 2'd2) begin
               fifo_ff[PtrWidth'(wr_ptr_ff + 1'b1)] <= res1;
            end
            wr_ptr_ff <= PtrWidth'(wr_ptr_ff + PtrWidth'(nres));
         end

         if (pop) begin
            rd_ptr_ff <= PtrWidth'(rd_ptr_ff + 1'b1);
         end

         cnt_ff <= CountWidth'(cnt_ff + (advance ? CountWidth'(nres) : CountWidth'(0))
                   - (pop ? CountWidth'(1) : CountWidth'(0)));
      end
   end

`ifndef NO_ASSERTIONS
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CountWidth'(FifoDepth))
      else $error("result queue overflow");

   a_eom_rearm: assert property (@(posedge clock) disable iff (reset)
      (advance && in_eom_ff) |=> (phase_ff == PH_HEADER && hdr_cnt_ff == 3'd0))
      else $error("parser not rearmed after end of message");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)
                                     && $stable(in_eom_ff)))
      else $error("held byte lost while stalled");

   a_room_for_two: assert property (@(posedge clock) disable iff (reset)
      advance |-> (cnt_ff + CountWidth'(2) <= CountWidth'(FifoDepth)
                   || cnt_ff == CountWidth'(FifoDepth - 2)))
      else $error("queue lacks room for a full transaction");
`endif

endmodule
